// File: rtl/lrd_pkg.sv
package lrd_pkg;

    // Channel slots in the item format, and how many of them are built
    localparam int SLOTS    = 4;
    localparam int CHANNELS = 4;

    localparam int CH_W      = 2;
    localparam int MODE_W    = 2;
    localparam int LEVEL_W   = 8;
    localparam int PERCENT_W = 7;
    localparam int INTV_W    = 16;
    localparam int ELAPSED_W = 17;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX   = 8'd255;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [INTV_W-1:0]    STEP_INTERVAL_RESET = 16'd3921;

    // Percent scaling: floor(l*100/255) == ((l*100 + 1) * 257) >> 16
    localparam int PCT_PROD_W = 23;
    localparam logic [PCT_PROD_W-1:0] PCT_MUL = 23'd25700;
    localparam logic [PCT_PROD_W-1:0] PCT_ADD = 23'd257;

    typedef enum logic [MODE_W-1:0] {
        MODE_AUTO_OFF = 2'd0,
        MODE_AUTO_ON  = 2'd1,
        MODE_MAN_OFF  = 2'd2,
        MODE_MAN_ON   = 2'd3
    } lrd_mode_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_AUTO     = 2'd1,
        KIND_OVERRIDE = 2'd2
    } lrd_kind_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CH_W-1:0]   channel;
        logic              turn_on;
        logic [MODE_W-1:0] new_mode_warm_white;
        logic [MODE_W-1:0] new_mode_red;
        logic [MODE_W-1:0] new_mode_cold_white;
        logic [MODE_W-1:0] new_mode_blue;
    } lrd_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level_warm_white;
        logic [LEVEL_W-1:0]   level_red;
        logic [LEVEL_W-1:0]   level_cold_white;
        logic [LEVEL_W-1:0]   level_blue;
        logic [PERCENT_W-1:0] percent_warm_white;
        logic [PERCENT_W-1:0] percent_red;
        logic [PERCENT_W-1:0] percent_cold_white;
        logic [PERCENT_W-1:0] percent_blue;
        logic [MODE_W-1:0]    mode_warm_white;
        logic [MODE_W-1:0]    mode_red;
        logic [MODE_W-1:0]    mode_cold_white;
        logic [MODE_W-1:0]    mode_blue;
    } lrd_out_t;

    // Per-channel control for one accepted transfer
    typedef struct packed {
        logic              step;
        logic              auto_cmd;
        logic              turn_on;
        logic              override;
        logic [MODE_W-1:0] override_mode;
    } lrd_chan_ctrl_t;

    function automatic logic [PERCENT_W-1:0] lrd_percent(input logic [LEVEL_W-1:0] level);
        logic [PCT_PROD_W-1:0] prod;
        prod = PCT_PROD_W'(level) * PCT_MUL + PCT_ADD;
        return prod[PCT_PROD_W-1:16];
    endfunction

endpackage

// File: rtl/lrd_chan.sv
// One LED channel: mode and brightness registers with step and mode update.
// The outputs show the values after the current control has been applied.
module lrd_chan
    import lrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrd_chan_ctrl_t       ctrl,
    output logic [MODE_W-1:0]    mode,
    output logic [LEVEL_W-1:0]   level,
    output logic [PERCENT_W-1:0] percent
);

    lrd_mode_t          mode_reg, mode_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               is_manual;

    assign is_manual = (mode_reg == MODE_MAN_OFF) || (mode_reg == MODE_MAN_ON);

    // Update mode: override always, automatic command only outside manual modes
    always_comb
    begin
        mode_next = mode_reg;
        if (ctrl.override)
        begin
            mode_next = lrd_mode_t'(ctrl.override_mode);
        end
        else if (ctrl.auto_cmd && !is_manual)
        begin
            mode_next = ctrl.turn_on ? MODE_AUTO_ON : MODE_AUTO_OFF;
        end
    end

    // Step brightness by the current mode
    always_comb
    begin
        level_next = level_reg;
        if (ctrl.step)
        begin
            case (mode_reg)
                MODE_AUTO_ON:
                begin
                    if (level_reg != LEVEL_MAX)
                    begin
                        level_next = level_reg + LEVEL_W'(1);
                    end
                end
                MODE_AUTO_OFF:
                begin
                    if (level_reg != '0)
                    begin
                        level_next = level_reg - LEVEL_W'(1);
                    end
                end
                MODE_MAN_ON:  level_next = LEVEL_MAX;
                default:      level_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_AUTO_OFF;
            level_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            level_reg <= level_next;
        end
    end

    assign mode    = mode_next;
    assign level   = level_next;
    assign percent = lrd_percent(level_next);

endmodule

// File: rtl/four_channel_led_ramp_dimmer.sv
// Four-channel LED ramp dimmer (warm white, red, cold white, blue). Each accepted
// item (millisecond tick, automatic on/off command, or mode override for all
// channels) yields exactly one result holding every channel's level, percent
// (floor of level*100/255) and mode after the item is applied. One item is
// accepted per clock cycle while in_ready is high; its result is registered in
// the output register, and in_ready stays high as long as that register is
// empty or being drained. The channel and elapsed-count registers update as
// each item is accepted. A step of all channels happens on the tick at which
// the saturating elapsed count exceeds the step interval, after which the count
// restarts from zero. The interval register resets to 3921 and should be written
// only while the block is idle.
module four_channel_led_ramp_dimmer
    import lrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lrd_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lrd_out_t          out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [INTV_W-1:0] cfg_data
);

    logic [INTV_W-1:0]    interval_reg;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic                 out_valid_reg, out_valid_next;
    lrd_out_t             out_data_reg, out_data_next;

    logic accept, tick, step;

    logic [MODE_W-1:0]    new_mode [SLOTS];
    lrd_chan_ctrl_t       ctrl     [SLOTS];
    logic [MODE_W-1:0]    ch_mode  [SLOTS];
    logic [LEVEL_W-1:0]   ch_level [SLOTS];
    logic [PERCENT_W-1:0] ch_pct   [SLOTS];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Hold the step interval
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= STEP_INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            interval_reg <= cfg_data;
        end
    end

    // Advance the saturating elapsed count, restart it on a step
    assign tick        = accept && (in_data.mode == KIND_TICK);
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + ELAPSED_W'(1);
    assign step        = tick && (elapsed_inc > ELAPSED_W'(interval_reg));

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (step)
        begin
            elapsed_next = '0;
        end
        else if (tick)
        begin
            elapsed_next = elapsed_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

    // Route override modes by slot
    assign new_mode[0] = in_data.new_mode_warm_white;
    assign new_mode[1] = in_data.new_mode_red;
    assign new_mode[2] = in_data.new_mode_cold_white;
    assign new_mode[3] = in_data.new_mode_blue;

    for (genvar s = 0; s < SLOTS; s++)
    begin : g_slot
        if (s < CHANNELS)
        begin : g_live
            always_comb
            begin
                ctrl[s].step          = step;
                ctrl[s].auto_cmd      = accept && (in_data.mode == KIND_AUTO)
                                        && (in_data.channel == CH_W'(s));
                ctrl[s].turn_on       = in_data.turn_on;
                ctrl[s].override      = accept && (in_data.mode == KIND_OVERRIDE);
                ctrl[s].override_mode = new_mode[s];
            end

            lrd_chan u_chan (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl[s]),
                .mode    (ch_mode[s]),
                .level   (ch_level[s]),
                .percent (ch_pct[s])
            );
        end
        else
        begin : g_absent
            // Drop commands for channels that are not built, report zero
            assign ctrl[s]     = '0;
            assign ch_mode[s]  = '0;
            assign ch_level[s] = '0;
            assign ch_pct[s]   = '0;
        end
    end

    // Gather the result from the updated channel state
    always_comb
    begin
        out_data_next.level_warm_white   = ch_level[0];
        out_data_next.level_red          = ch_level[1];
        out_data_next.level_cold_white   = ch_level[2];
        out_data_next.level_blue         = ch_level[3];
        out_data_next.percent_warm_white = ch_pct[0];
        out_data_next.percent_red        = ch_pct[1];
        out_data_next.percent_cold_white = ch_pct[2];
        out_data_next.percent_blue       = ch_pct[3];
        out_data_next.mode_warm_white    = ch_mode[0];
        out_data_next.mode_red           = ch_mode[1];
        out_data_next.mode_cold_white    = ch_mode[2];
        out_data_next.mode_blue          = ch_mode[3];
    end

    // Load the result register on an input transfer, clear valid on an output transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/lrd_checker.sv
module lrd_checker
    import lrd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input lrd_out_t          out_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [INTV_W-1:0] cfg_data
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Every input transfer produces a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input transfer without a result");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Full brightness reports full percent
    a_pct_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.level_red == LEVEL_MAX) |->
        (out_data.percent_red == lrd_percent(LEVEL_MAX)))
        else $error("percent does not match full level");

    // A configuration write is always taken, with defined data
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
        else $error("configuration write not taken");

endmodule

bind four_channel_led_ramp_dimmer lrd_checker u_lrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

// File: tb/sv/led_dimmer_checker.sv
module led_dimmer_checker
    import lrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  lrd_in_t           in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  lrd_out_t          out_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [INTV_W-1:0] cfg_data,
    output int unsigned       mismatches,
    output int unsigned       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the dimmer state
    lrd_mode_t             chan_mode [SLOTS];
    logic [LEVEL_W-1:0]    chan_level [SLOTS];
    logic [ELAPSED_W-1:0]  elapsed;
    logic [INTV_W-1:0]     interval;

    lrd_out_t              expected_states [$];
    int unsigned           results_seen;

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    function automatic logic [PERCENT_W-1:0] level_to_percent(input logic [LEVEL_W-1:0] lvl);
        return PERCENT_W'((int'(lvl) * 100) / 255);
    endfunction

    task automatic reset_model();
        int c;
        for (c = 0; c < SLOTS; c++)
        begin
            chan_mode[c]  = MODE_AUTO_OFF;
            chan_level[c] = '0;
        end
        elapsed  = '0;
        interval = STEP_INTERVAL_RESET;
        expected_states.delete();
    endtask

    // Apply one accepted item to the shadow state and queue the state it leaves
    task automatic advance_dimmer(input lrd_in_t it);
        lrd_mode_t          new_mode [SLOTS];
        logic [LEVEL_W-1:0] lv [SLOTS];
        lrd_mode_t          md [SLOTS];
        lrd_out_t           exp_state;
        int                 c;

        new_mode[0] = lrd_mode_t'(it.new_mode_warm_white);
        new_mode[1] = lrd_mode_t'(it.new_mode_red);
        new_mode[2] = lrd_mode_t'(it.new_mode_cold_white);
        new_mode[3] = lrd_mode_t'(it.new_mode_blue);

        case (it.mode)
            KIND_TICK:
            begin
                if (elapsed != ELAPSED_MAX)
                    elapsed = elapsed + 1'b1;
                if (elapsed > {1'b0, interval})
                begin
                    // Step every live channel once, then restart the count
                    for (c = 0; c < CHANNELS; c++)
                    begin
                        case (chan_mode[c])
                            MODE_AUTO_ON:
                            begin
                                if (chan_level[c] < LEVEL_MAX)
                                    chan_level[c] = chan_level[c] + 1'b1;
                            end
                            MODE_AUTO_OFF:
                            begin
                                if (chan_level[c] != '0)
                                    chan_level[c] = chan_level[c] - 1'b1;
                            end
                            MODE_MAN_ON:
                                chan_level[c] = LEVEL_MAX;
                            default:
                                chan_level[c] = '0;
                        endcase
                    end
                    elapsed = '0;
                end
            end
            KIND_AUTO:
            begin
                // Manual modes lock out automatic commands
                if (int'(it.channel) < CHANNELS &&
                    chan_mode[it.channel] != MODE_MAN_ON &&
                    chan_mode[it.channel] != MODE_MAN_OFF)
                    chan_mode[it.channel] = it.turn_on ? MODE_AUTO_ON : MODE_AUTO_OFF;
            end
            KIND_OVERRIDE:
            begin
                for (c = 0; c < CHANNELS; c++)
                    chan_mode[c] = new_mode[c];
            end
            default:
                ;
        endcase

        // Channels that are not built report zero everywhere
        for (c = 0; c < SLOTS; c++)
        begin
            lv[c] = (c < CHANNELS) ? chan_level[c] : '0;
            md[c] = (c < CHANNELS) ? chan_mode[c] : MODE_AUTO_OFF;
        end

        exp_state.level_warm_white   = lv[0];
        exp_state.level_red          = lv[1];
        exp_state.level_cold_white   = lv[2];
        exp_state.level_blue         = lv[3];
        exp_state.percent_warm_white = level_to_percent(lv[0]);
        exp_state.percent_red        = level_to_percent(lv[1]);
        exp_state.percent_cold_white = level_to_percent(lv[2]);
        exp_state.percent_blue       = level_to_percent(lv[3]);
        exp_state.mode_warm_white    = md[0];
        exp_state.mode_red           = md[1];
        exp_state.mode_cold_white    = md[2];
        exp_state.mode_blue          = md[3];
        expected_states.push_back(exp_state);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in result %0d, %s: expected %0d, got %0d",
                         results_seen, name, want, got);
        end
    endtask

    task automatic compare_result(input lrd_out_t got);
        lrd_out_t want;
        want = expected_states.pop_front();
        check_field("level_warm_white",   want.level_warm_white,   got.level_warm_white);
        check_field("level_red",          want.level_red,          got.level_red);
        check_field("level_cold_white",   want.level_cold_white,   got.level_cold_white);
        check_field("level_blue",         want.level_blue,         got.level_blue);
        check_field("percent_warm_white", want.percent_warm_white, got.percent_warm_white);
        check_field("percent_red",        want.percent_red,        got.percent_red);
        check_field("percent_cold_white", want.percent_cold_white, got.percent_cold_white);
        check_field("percent_blue",       want.percent_blue,       got.percent_blue);
        check_field("mode_warm_white",    want.mode_warm_white,    got.mode_warm_white);
        check_field("mode_red",           want.mode_red,           got.mode_red);
        check_field("mode_cold_white",    want.mode_cold_white,    got.mode_cold_white);
        check_field("mode_blue",          want.mode_blue,          got.mode_blue);
    endtask

    // Watch all four channels; retire results before queueing new ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_states.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no item outstanding", results_seen);
                end
                else
                begin
                    compare_result(out_data);
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                interval = cfg_data;
            if (in_valid && in_ready)
                advance_dimmer(in_data);
        end
        pending = expected_states.size();
    end

endmodule

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrd_pkg::*;

    localparam int          IN_W        = $bits(lrd_in_t);
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    lrd_in_t           in_data;
    logic              out_valid;
    logic              out_ready;
    lrd_out_t          out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [INTV_W-1:0] cfg_data;

    int unsigned       mismatches;
    int unsigned       pending;
    int unsigned       long_holds_req;
    int unsigned       long_holds_done;
    int unsigned       cycle_count;
    bit                feed_gaps_on;
    bit                drain_gaps_on;

    four_channel_led_ramp_dimmer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    led_dimmer_checker dimmer_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic lrd_in_t noise_item();
        lrd_in_t it;
        it = IN_W'($urandom);
        return it;
    endfunction

    function automatic lrd_in_t tick_item();
        lrd_in_t it;
        it = noise_item();
        it.mode = KIND_TICK;
        return it;
    endfunction

    function automatic lrd_in_t auto_item(input int unsigned ch, input bit on);
        lrd_in_t it;
        it = noise_item();
        it.mode    = KIND_AUTO;
        it.channel = CH_W'(ch);
        it.turn_on = on;
        return it;
    endfunction

    function automatic lrd_in_t override_item(input lrd_mode_t ww, input lrd_mode_t rd,
                                              input lrd_mode_t cw, input lrd_mode_t bl);
        lrd_in_t it;
        it = noise_item();
        it.mode                = KIND_OVERRIDE;
        it.new_mode_warm_white = ww;
        it.new_mode_red        = rd;
        it.new_mode_cold_white = cw;
        it.new_mode_blue       = bl;
        return it;
    endfunction

    function automatic lrd_in_t random_item();
        lrd_in_t     it;
        int unsigned r;
        it = noise_item();
        r  = $urandom_range(0, 99);
        if (r < 70)
            it.mode = KIND_TICK;
        else if (r < 82)
            it.mode = KIND_AUTO;
        else if (r < 94)
            it.mode = KIND_OVERRIDE;
        else
            it.mode = KIND_UNUSED;
        return it;
    endfunction

    function automatic logic [INTV_W-1:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return INTV_W'($urandom_range(0, 6));
        else if (r < 85)
            return INTV_W'($urandom_range(7, 40));
        else if (r < 95)
            return INTV_W'($urandom);
        else
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    // Offer one item and hold it until the transfer; entered and left at a falling edge
    task automatic push_item(input lrd_in_t it, input bit paced);
        int unsigned gap;
        gap = 0;
        if (paced)
        begin
            if ($urandom_range(0, 59) == 0)
                feed_gaps_on = !feed_gaps_on;
            if (feed_gaps_on)
                gap = pick_gap();
        end
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_ticks(input int unsigned n, input bit paced);
        repeat (n)
            push_item(tick_item(), paced);
    endtask

    // Drain the block, then write the step interval
    task automatic write_interval(input logic [INTV_W-1:0] value);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: random stalls, quiet stretches, and long hold-offs on request
    initial
    begin
        int unsigned stall_left;
        int unsigned stall;
        out_ready       = 1'b0;
        stall_left      = 0;
        long_holds_done = 0;
        drain_gaps_on   = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 149) == 0)
                drain_gaps_on = !drain_gaps_on;
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (long_holds_done < long_holds_req)
            begin
                long_holds_done++;
                out_ready  = 1'b0;
                stall_left = LONG_HOLD - 1;
            end
            else
            begin
                stall = drain_gaps_on ? pick_gap() : 0;
                if (stall > 0)
                begin
                    out_ready  = 1'b0;
                    stall_left = stall - 1;
                end
                else
                begin
                    out_ready = 1'b1;
                end
            end
        end
    end

    // Give up if the run stalls
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned ph;
        int unsigned c;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        long_holds_req = 0;
        feed_gaps_on   = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset interval: lockout of manual channels, unused kind, no step in a short run
        push_item(random_item(), 1'b1);
        in_data.mode = KIND_UNUSED;
        push_item(in_data, 1'b1);
        push_item(override_item(MODE_AUTO_ON, MODE_AUTO_OFF, MODE_MAN_ON, MODE_MAN_OFF), 1'b1);
        push_item(auto_item(2, 1'b0), 1'b1);
        push_item(auto_item(3, 1'b1), 1'b1);
        push_item(auto_item(1, 1'b1), 1'b1);
        push_item(auto_item(0, 1'b1), 1'b1);
        run_ticks(20, 1'b0);
        run_ticks(3, 1'b1);

        // Interval zero: ramp every channel to full, then back down to dark
        write_interval('0);
        push_item(override_item(MODE_AUTO_ON, MODE_AUTO_ON, MODE_AUTO_ON, MODE_AUTO_ON), 1'b1);
        run_ticks(258, 1'b0);
        for (c = 0; c < SLOTS; c++)
            push_item(auto_item(c, 1'b0), 1'b1);
        run_ticks(258, 1'b0);
        push_item(override_item(MODE_MAN_ON, MODE_MAN_ON, MODE_MAN_ON, MODE_MAN_ON), 1'b1);
        push_item(auto_item(3, 1'b0), 1'b1);
        run_ticks(1, 1'b1);
        push_item(override_item(MODE_MAN_OFF, MODE_MAN_OFF, MODE_MAN_OFF, MODE_MAN_OFF), 1'b1);
        push_item(auto_item(0, 1'b1), 1'b1);
        run_ticks(1, 1'b1);
        push_item(override_item(MODE_AUTO_OFF, MODE_AUTO_OFF, MODE_AUTO_OFF, MODE_AUTO_OFF),
                  1'b1);

        // Widest interval: no step over a short run of ticks
        write_interval('1);
        push_item(override_item(MODE_AUTO_ON, MODE_MAN_ON, MODE_AUTO_ON, MODE_MAN_OFF), 1'b1);
        run_ticks(30, 1'b0);

        // Random phases, each with its own interval
        for (ph = 0; ph < 10; ph++)
        begin
            write_interval(pick_interval());
            if (ph == 0 || ph == 5)
                long_holds_req++;
            repeat (40)
                push_item(random_item(), 1'b1);
        end

        // Drain and report
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/lrd_pkg.sv
rtl/lrd_chan.sv
rtl/four_channel_led_ramp_dimmer.sv
rtl/lrd_checker.sv
tb/sv/led_dimmer_checker.sv
tb/sv/tb.sv
